FILE: hdl/arpc_pkg.sv
`default_nettype none

package arpc_pkg;

  localparam int unsigned IP_W  = 32;
  localparam int unsigned MAC_W = 48;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_addr;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [MAC_W-1:0] mac_out;
  } out_word_t;

  typedef struct packed {
    logic             valid;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/arpc_cell.sv
`default_nettype none

module arpc_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  arpc_pkg::cell_ctrl_t         ctrl,
  input  arpc_pkg::in_word_t           key,
  input  arpc_pkg::entry_t             prev_entry,
  input  wire                          seen_i,
  output arpc_pkg::entry_t             entry_o,
  output logic                         seen_o,
  output logic [arpc_pkg::MAC_W-1:0]   hit_mac_o
);

  logic                       valid_r;
  logic [arpc_pkg::IP_W-1:0]  ip_r;
  logic [arpc_pkg::MAC_W-1:0] mac_r;
  logic                       match_r;
  logic                       match_nxt;
  logic                       load;

  assign match_nxt = valid_r & ((key.kind == arpc_pkg::KIND_LOOKUP) ?
                                (ip_r == key.ip_addr) : (mac_r == key.mac_addr));

  assign load = ctrl.shift & ~seen_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= prev_entry.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ip_r  <= prev_entry.ip;
      mac_r <= prev_entry.mac;
    end
    if (ctrl.capture) begin
      match_r <= match_nxt;
    end
  end

  assign entry_o   = '{valid: valid_r, ip: ip_r, mac: mac_r};
  assign seen_o    = seen_i | match_r;
  assign hit_mac_o = (match_r & ~seen_i) ? mac_r : '0;

endmodule

`default_nettype wire

FILE: hdl/arp_cache_lru_unit.sv
// Address resolution cache held as a row of cells in recency order, the most
// recent entry in the first cell. A word is taken when start is high and busy
// is low; the key is compared in every cell at that edge, and on the next edge
// an update shifts the row by one cell up to the hit (or across the whole row on
// a miss, dropping the least recent entry) while the result is registered; a
// lookup leaves the row as it is. Each word therefore passes through the compare
// stage followed by the shift stage, and out_strobe marks the result for one
// cycle right after busy falls. The receiver cannot stall, so a result must be
// taken in the cycle it is shown; a new word can be accepted in that same cycle.
`default_nettype none

module arp_cache_lru_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  arpc_pkg::in_word_t    in_word,
  output logic                  out_strobe,
  output arpc_pkg::out_word_t   out_word
);

  arpc_pkg::state_t           state_r;
  arpc_pkg::state_t           state_nxt;
  arpc_pkg::in_word_t         req_r;
  arpc_pkg::cell_ctrl_t       ctrl;
  arpc_pkg::entry_t           new_entry;
  arpc_pkg::entry_t           ent [ENTRIES];
  logic [ENTRIES:0]           seen;
  logic [arpc_pkg::MAC_W-1:0] hit_mac [ENTRIES];
  logic [arpc_pkg::MAC_W-1:0] hit_mac_any;
  logic [ENTRIES-1:0]         vld;
  logic                       accept;
  logic                       apply;
  logic                       out_strobe_r;
  arpc_pkg::out_word_t        out_word_r;

  assign accept = start & ~busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      arpc_pkg::ST_IDLE:  if (start) state_nxt = arpc_pkg::ST_APPLY;
      arpc_pkg::ST_APPLY: state_nxt = arpc_pkg::ST_IDLE;
      default:            state_nxt = arpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b0;
    apply = 1'b0;
    unique case (state_r)
      arpc_pkg::ST_IDLE:  busy = 1'b0;
      arpc_pkg::ST_APPLY: begin
        busy  = 1'b1;
        apply = 1'b1;
      end
      default:            busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= arpc_pkg::ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= apply;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_word;
    end
    if (apply) begin
      out_word_r.found   <= seen[ENTRIES];
      out_word_r.mac_out <= (req_r.kind == arpc_pkg::KIND_LOOKUP) ? hit_mac_any : '0;
    end
  end

  assign ctrl.capture = accept;
  assign ctrl.shift   = apply & (req_r.kind == arpc_pkg::KIND_UPDATE);
  assign new_entry    = '{valid: 1'b1, ip: req_r.ip_addr, mac: req_r.mac_addr};
  assign seen[0]      = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    arpc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .key        (in_word),
      .prev_entry ((i == 0) ? new_entry : ent[(i == 0) ? 0 : i-1]),
      .seen_i     (seen[i]),
      .entry_o    (ent[i]),
      .seen_o     (seen[i+1]),
      .hit_mac_o  (hit_mac[i])
    );
    assign vld[i] = ent[i].valid;
  end

  always_comb begin
    hit_mac_any = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_mac_any = hit_mac_any | hit_mac[i];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // Each accepted word is worked on for exactly one apply cycle.
  a_single_apply: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("apply phase lasted more than one cycle");

  // A result follows every apply cycle and nothing else.
  a_strobe_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a preceding apply cycle");

  // Misses and updates never return a hardware address.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_word.found) |-> (out_word.mac_out == '0))
    else $error("nonzero address reported on a miss");

  // Valid entries always occupy a contiguous run starting at the first cell.
  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((({1'b0, vld} + 1'b1) & {1'b0, vld}) == '0))
    else $error("gap in the valid entries of the cell row");

endmodule

`default_nettype wire

FILE: verif/arp_cache_lru_unit_test.sv
module arp_cache_lru_unit_test;

  localparam int unsigned CACHE_DEPTH = 16;
  localparam int unsigned DIR_N = 22;
  localparam int unsigned PHASE_WORDS = 450;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned REPORT_MAX = 10;
  localparam logic [arpc_pkg::IP_W-1:0] IP_ONES = '1;
  localparam logic [arpc_pkg::MAC_W-1:0] MAC_ONES = '1;

  typedef struct {
    arpc_pkg::in_word_t  word;
    bit                  typed;
    arpc_pkg::out_word_t result;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  arpc_pkg::in_word_t  in_word;
  logic                out_strobe;
  arpc_pkg::out_word_t out_word;

  // Shadow copy of the cache, kept in slot order with recency ranks.
  bit                         cache_valid [CACHE_DEPTH];
  logic [arpc_pkg::IP_W-1:0]  cache_ip  [CACHE_DEPTH];
  logic [arpc_pkg::MAC_W-1:0] cache_mac [CACHE_DEPTH];
  int                         cache_rank  [CACHE_DEPTH];

  arpc_pkg::out_word_t        pending_results[$];
  logic [arpc_pkg::IP_W-1:0]  ip_pool [12];
  logic [arpc_pkg::MAC_W-1:0] mac_pool [24];
  dir_row_t                   dir_rows [DIR_N];
  int                         mismatch_count;
  int                         stall_cycles;

  arp_cache_lru_unit #(
    .ENTRIES(CACHE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .out_strobe(out_strobe),
    .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic dir_row_t row(input logic kind, input logic [arpc_pkg::IP_W-1:0] ip,
                                   input logic [arpc_pkg::MAC_W-1:0] mac, input bit typed,
                                   input logic found,
                                   input logic [arpc_pkg::MAC_W-1:0] mac_out);
    dir_row_t r;
    r.word.kind = kind;
    r.word.ip_addr = ip;
    r.word.mac_addr = mac;
    r.typed = typed;
    r.result.found = found;
    r.result.mac_out = mac_out;
    return r;
  endfunction

  // Ages every valid slot more recent than the limit and makes sel the newest.
  function automatic void make_newest(input int sel, input int limit);
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (i != sel && cache_valid[i] && cache_rank[i] < limit) begin
        cache_rank[i]++;
      end
    end
    cache_rank[sel] = 0;
  endfunction

  function automatic arpc_pkg::out_word_t resolve_word(input arpc_pkg::in_word_t w);
    arpc_pkg::out_word_t r;
    bit hit;
    bit have_free;
    int sel;
    int free_slot;
    int oldest;
    int oldest_rank;
    r = '0;
    hit = 1'b0;
    have_free = 1'b0;
    sel = 0;
    free_slot = 0;
    oldest = 0;
    oldest_rank = 0;
    if (w.kind == arpc_pkg::KIND_UPDATE) begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (cache_valid[i]) begin
          if (!hit && cache_mac[i] == w.mac_addr) begin
            hit = 1'b1;
            sel = i;
          end
          if (cache_rank[i] >= oldest_rank) begin
            oldest_rank = cache_rank[i];
            oldest = i;
          end
        end else if (!have_free) begin
          have_free = 1'b1;
          free_slot = i;
        end
      end
      if (hit) begin
        cache_ip[sel] = w.ip_addr;
        make_newest(sel, cache_rank[sel]);
        r.found = 1'b1;
      end else if (have_free) begin
        cache_valid[free_slot] = 1'b1;
        cache_mac[free_slot] = w.mac_addr;
        cache_ip[free_slot] = w.ip_addr;
        make_newest(free_slot, CACHE_DEPTH);
      end else begin
        cache_mac[oldest] = w.mac_addr;
        cache_ip[oldest] = w.ip_addr;
        make_newest(oldest, oldest_rank);
      end
    end else begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (cache_valid[i] && cache_ip[i] == w.ip_addr) begin
          if (!hit || cache_rank[i] < oldest_rank) begin
            hit = 1'b1;
            oldest_rank = cache_rank[i];
            r.mac_out = cache_mac[i];
          end
        end
      end
      r.found = hit;
    end
    return r;
  endfunction

  function automatic arpc_pkg::in_word_t random_word();
    arpc_pkg::in_word_t w;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    w.kind = ($urandom_range(1) == 1) ? arpc_pkg::KIND_LOOKUP : arpc_pkg::KIND_UPDATE;
    if ($urandom_range(99) < 85) begin
      w.ip_addr = ip_pool[$urandom_range(11)];
      w.mac_addr = mac_pool[$urandom_range(23)];
    end else begin
      w.ip_addr = $urandom;
      w.mac_addr = raw[arpc_pkg::MAC_W-1:0];
    end
    return w;
  endfunction

  task automatic issue_word(input arpc_pkg::in_word_t w, input bit typed,
                            input arpc_pkg::out_word_t typed_result);
    arpc_pkg::out_word_t predicted;
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = resolve_word(w);
    pending_results.push_back(typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    arpc_pkg::out_word_t want;
    if (out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected result word: found=%0b mac=%012h", out_word.found,
                   out_word.mac_out);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_word.found !== want.found || out_word.mac_out !== want.mac_out) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("result mismatch: expected found=%0b mac=%012h, got found=%0b mac=%012h",
                     want.found, want.mac_out, out_word.found, out_word.mac_out);
          end
        end
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int idle_pct;
    logic [63:0] raw;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    mismatch_count = 0;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      cache_valid[i] = 1'b0;
      cache_ip[i] = '0;
      cache_mac[i] = '0;
      cache_rank[i] = 0;
    end
    for (int i = 0; i < 12; i++) begin
      ip_pool[i] = $urandom;
    end
    for (int i = 0; i < 24; i++) begin
      raw = {$urandom, $urandom};
      mac_pool[i] = raw[arpc_pkg::MAC_W-1:0];
    end
    dir_rows = '{
      row(arpc_pkg::KIND_LOOKUP, '0, '0, 1, 1'b0, '0),
      row(arpc_pkg::KIND_UPDATE, '0, '0, 1, 1'b0, '0),
      row(arpc_pkg::KIND_LOOKUP, '0, '0, 1, 1'b1, '0),
      row(arpc_pkg::KIND_UPDATE, IP_ONES, MAC_ONES, 1, 1'b0, '0),
      row(arpc_pkg::KIND_LOOKUP, IP_ONES, '0, 1, 1'b1, MAC_ONES),
      row(arpc_pkg::KIND_UPDATE, 32'h0A00_0001, '0, 1, 1'b1, '0),
      row(arpc_pkg::KIND_LOOKUP, '0, '0, 1, 1'b0, '0),
      row(arpc_pkg::KIND_UPDATE, IP_ONES, 48'h0123_4567_89AB, 1, 1'b0, '0),
      row(arpc_pkg::KIND_LOOKUP, IP_ONES, '0, 1, 1'b1, 48'h0123_4567_89AB),
      row(arpc_pkg::KIND_UPDATE, IP_ONES, MAC_ONES, 1, 1'b1, '0),
      row(arpc_pkg::KIND_LOOKUP, IP_ONES, '0, 1, 1'b1, MAC_ONES),
      row(arpc_pkg::KIND_LOOKUP, 32'h0A00_0001, MAC_ONES, 1, 1'b1, '0),
      row(arpc_pkg::KIND_UPDATE, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA, 0, 1'b0, '0),
      row(arpc_pkg::KIND_UPDATE, 32'h5555_5555, 48'h5555_5555_5555, 0, 1'b0, '0),
      row(arpc_pkg::KIND_LOOKUP, 32'hAAAA_AAAA, '0, 0, 1'b0, '0),
      row(arpc_pkg::KIND_LOOKUP, 32'h5555_5555, '0, 0, 1'b0, '0),
      row(arpc_pkg::KIND_UPDATE, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, 0, 1'b0, '0),
      row(arpc_pkg::KIND_LOOKUP, 32'h5555_5555, '0, 0, 1'b0, '0),
      row(arpc_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, '0, 0, 1'b0, '0),
      row(arpc_pkg::KIND_UPDATE, 32'h8000_0000, 48'h8000_0000_0000, 0, 1'b0, '0),
      row(arpc_pkg::KIND_LOOKUP, 32'h8000_0000, '0, 0, 1'b0, '0),
      row(arpc_pkg::KIND_LOOKUP, 32'h0000_0001, '0, 0, 1'b0, '0)
    };
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < DIR_N; i++) begin
      issue_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].result);
    end
    // The sender idles rarely, then mostly, then never.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 7 : ((phase == 1) ? 88 : 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        while ($urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          @(negedge clk);
        end
        issue_word(random_word(), 1'b0, '0);
      end
    end
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
